// ----- design/skgc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the soft knee gain computer.
// No dependencies.
package skgc_pkg;

    localparam int LEVEL_W = 16;
    localparam int CFG_W   = 15;
    localparam int DIV_W   = 64;
    localparam int QUO_W   = 16;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_RATIO     = 2'd1,
        CFG_KNEE      = 2'd2,
        CFG_RANGE     = 2'd3
    } t_cfg_idx;

    localparam logic signed [14:0] THRESHOLD_RST = -15'sd5120;
    localparam logic [14:0]        RATIO_RST     = 15'd1024;
    localparam logic [7:0]         KNEE_RST      = 8'd0;
    localparam logic [14:0]        RANGE_RST     = 15'd30720;
    localparam logic [14:0]        RATIO_UNITY   = 15'd256;
    localparam logic [6:0]         KNEE_MAX      = 7'd100;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic             sat;
        logic             zero;
    } t_div;

endpackage

// ----- design/soft_knee_gain_computer.sv -----
`timescale 1ns / 1ps
// Soft knee gain computer, top level.
// Depends on skgc_pkg.
//
// Takes one level per cycle (start high while busy is low; busy is always low)
// and returns its gain change on o_valid. The pipeline has an input register,
// four arithmetic stages, a 16 stage restoring divider with one quotient bit per
// stage, and the output register. Configuration writes take effect for
// transactions started after the write and must not overlap transactions in
// flight. The result strobe cannot be held off by the receiver.
module soft_knee_gain_computer #(
    parameter logic [14:0] UNLIMITED_RANGE = 15'd30720
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic signed [15:0] i_level_db,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    output logic        o_valid,
    output logic signed [15:0] o_gain_change_db
);

    localparam int NSTG = skgc_pkg::QUO_W;
    localparam int LAT  = NSTG + 6;

    logic signed [14:0] r_thr;
    logic [14:0]        r_ratio;
    logic [7:0]         r_knee;
    logic [14:0]        r_range;

    logic [14:0] n_rat;
    logic [14:0] r_rat;
    logic        r_boost;
    logic        r_unity;
    logic [14:0] r_slope;
    logic [14:0] abs_t;
    logic [6:0]  kp;
    logic [20:0] r_h100;
    logic [23:0] r_r400;
    logic [44:0] r_den;
    logic [14:0] bound;

    logic                      r_s0_vld;
    logic signed [15:0]        r_s0_x;
    logic                      r_s1_vld;
    logic                      r_s1_zero;
    logic                      r_s1_hard;
    logic [21:0]               r_s1_op;
    logic                      r_s2_vld;
    logic                      r_s2_zero;
    logic                      r_s2_hard;
    logic [43:0]               r_s2_p;
    logic                      r_s3_vld;
    logic                      r_s3_zero;
    logic                      r_s3_hard;
    logic [58:0]               r_s3_num;

    logic signed [16:0] d;
    logic signed [23:0] d100;
    logic signed [23:0] hs;
    logic               s1_zero;
    logic               s1_hard;
    logic [63:0]        den_sel;
    logic [63:0]        num_n;

    skgc_pkg::t_div r_dv [0:NSTG];
    logic [NSTG:0]  r_dv_vld;
    skgc_pkg::t_div n_dv [1:NSTG];

    logic [15:0] mag;
    logic [15:0] mag_c;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= skgc_pkg::THRESHOLD_RST;
            r_ratio <= skgc_pkg::RATIO_RST;
            r_knee  <= skgc_pkg::KNEE_RST;
            r_range <= skgc_pkg::RANGE_RST;
        end else if (i_cfg_we) begin
            unique case (skgc_pkg::t_cfg_idx'(i_cfg_idx))
                skgc_pkg::CFG_THRESHOLD: r_thr   <= $signed(i_cfg_data);
                skgc_pkg::CFG_RATIO:     r_ratio <= i_cfg_data;
                skgc_pkg::CFG_KNEE:      r_knee  <= i_cfg_data[7:0];
                skgc_pkg::CFG_RANGE:     r_range <= i_cfg_data;
            endcase
        end
    end

    // derived constants; the user must keep them stable while transactions are in flight, the block does not enforce it
    assign n_rat = (r_ratio == 15'd0) ? 15'd1 : r_ratio;
    assign abs_t = r_thr[14] ? 15'(-r_thr) : 15'(r_thr);
    assign kp    = (r_knee > 8'(skgc_pkg::KNEE_MAX)) ? skgc_pkg::KNEE_MAX : r_knee[6:0];
    assign bound = (r_range < UNLIMITED_RANGE) ? r_range : UNLIMITED_RANGE;

    always_ff @(posedge i_clk) begin
        r_rat   <= n_rat;
        r_boost <= n_rat < skgc_pkg::RATIO_UNITY;
        r_unity <= n_rat == skgc_pkg::RATIO_UNITY;
        r_slope <= (n_rat < skgc_pkg::RATIO_UNITY) ? skgc_pkg::RATIO_UNITY - n_rat
                                                   : n_rat - skgc_pkg::RATIO_UNITY;
        r_h100  <= {14'd0, kp} * {6'd0, abs_t};
        r_r400  <= 24'(n_rat * 24'd400);
        r_den   <= {21'd0, r_r400} * {24'd0, r_h100};
    end

    // stage 1: offset from threshold and knee region
    assign d    = {r_s0_x[15], r_s0_x} - {{2{r_thr[14]}}, r_thr};
    assign d100 = 24'({{7{d[16]}}, d} * 24'sd100);
    assign hs   = $signed({3'b000, r_h100});
    assign s1_zero = d100 < -hs;
    assign s1_hard = !s1_zero && ((d100 > hs) || (r_h100 == 21'd0));

    // stage 4: rounding folded into the operands, N = 2num + den, D = 2den
    assign den_sel = r_s3_hard ? 64'(r_rat) : 64'(r_den);
    assign num_n   = {4'd0, r_s3_num, 1'b0} + den_sel;

    always_ff @(posedge i_clk) begin
        r_s0_x    <= i_level_db;
        r_s1_zero <= s1_zero;
        r_s1_hard <= s1_hard;
        r_s1_op   <= s1_hard ? 22'(d) : 22'(d100 + hs);
        r_s2_zero <= r_s1_zero;
        r_s2_hard <= r_s1_hard;
        r_s2_p    <= r_s1_hard ? {22'd0, r_s1_op} * {29'd0, r_slope}
                               : {22'd0, r_s1_op} * {22'd0, r_s1_op};
        r_s3_zero <= r_s2_zero;
        r_s3_hard <= r_s2_hard;
        r_s3_num  <= r_s2_hard ? {15'd0, r_s2_p} : {15'd0, r_s2_p} * {44'd0, r_slope};
        r_dv[0].rem  <= num_n;
        r_dv[0].dvs  <= den_sel << 1;
        r_dv[0].quo  <= '0;
        r_dv[0].sat  <= num_n >= (den_sel << (NSTG + 1));
        r_dv[0].zero <= r_s3_zero;
    end

    genvar j;
    generate
        for (j = 0; j < NSTG; j++) begin : g_div
            localparam int K = NSTG - 1 - j;
            logic [63:0] trial;
            logic        ge;
            assign trial = r_dv[j].dvs << K;
            assign ge    = r_dv[j].rem >= trial;
            always_comb begin
                n_dv[j+1]        = r_dv[j];
                n_dv[j+1].quo[K] = ge;
                if (ge) begin
                    n_dv[j+1].rem = r_dv[j].rem - trial;
                end
            end
            always_ff @(posedge i_clk) begin
                r_dv[j+1] <= n_dv[j+1];
            end
        end
    endgenerate

    assign mag   = r_dv[NSTG].sat ? 16'hFFFF : r_dv[NSTG].quo;
    assign mag_c = (mag > {1'b0, bound}) ? {1'b0, bound} : mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_dv_vld <= '0;
            o_valid  <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_dv_vld <= {r_dv_vld[NSTG-1:0], r_s3_vld};
            o_valid  <= r_dv_vld[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_dv[NSTG].zero || r_unity) begin
            o_gain_change_db <= '0;
        end else if (r_boost) begin
            o_gain_change_db <= $signed(mag_c);
        end else begin
            o_gain_change_db <= $signed(16'(-mag_c));
        end
    end

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without matching transaction");
    a_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_unity) |-> (o_gain_change_db == 16'sd0))
        else $error("unity ratio gave nonzero gain");
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_gain_change_db <= $signed({1'b0, bound}))
                  && (o_gain_change_db >= -$signed({1'b0, bound}))))
        else $error("gain change beyond bound");
    a_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_boost) |-> (o_gain_change_db <= 16'sd0))
        else $error("downward ratio gave a boost");
`endif

endmodule
